>>> hw/rtl/olip_pkg.sv
// ----------------------------------------------------------------------------
// olip_pkg
// Shared widths, codes and types for the ordered list insert block.
// ----------------------------------------------------------------------------
package olip_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 5;
   localparam int DATA_W   = 32;
   localparam int CMP_W    = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;

   typedef logic [IDX_W-1:0]         idx_type;
   typedef logic [CNT_W-1:0]         cnt_type;
   typedef logic [POS_W-1:0]         pos_type;
   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [1:0]               status_type;

   localparam logic       CMD_INSERT = 1'b0;
   localparam logic       CMD_DUMP   = 1'b1;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_BADPOS = 2'd1;
   localparam status_type ST_FULL   = 2'd2;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_ROTATE
   } op_type;

   typedef struct packed {
      op_type   op;
      idx_type  ins_idx;
      idx_type  tail_idx;
      data_type value;
   } cell_ctrl_type;

endpackage

>>> hw/rtl/olip_req_if.sv
// ----------------------------------------------------------------------------
// olip_req_if
// Request channel: insert or dump item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface olip_req_if;
   import olip_pkg::*;

   logic     valid;
   logic     ready;
   logic     cmd;
   data_type value;
   pos_type  position;

   modport source (output valid, output cmd, output value, output position, input ready);
   modport sink   (input valid, input cmd, input value, input position, output ready);
endinterface

>>> hw/rtl/olip_rsp_if.sv
// ----------------------------------------------------------------------------
// olip_rsp_if
// Response channel: status or dumped element with valid/ready handshake.
// ----------------------------------------------------------------------------
interface olip_rsp_if;
   import olip_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   data_type   element;
   logic       last;

   modport source (output valid, output status, output element, output last, input ready);
   modport sink   (input valid, input status, input element, input last, output ready);
endinterface

>>> hw/rtl/olip_cell.sv
// ----------------------------------------------------------------------------
// olip_cell
// One list slot: holds a value, shifts back on insert, rotates forward on dump.
// ----------------------------------------------------------------------------
module olip_cell (
   input  logic                   clock,
   input  olip_pkg::idx_type       cell_idx,
   input  olip_pkg::cell_ctrl_type ctrl,
   input  olip_pkg::data_type      prev_value,
   input  olip_pkg::data_type      next_value,
   input  olip_pkg::data_type      head_value,
   output olip_pkg::data_type      value
);
   import olip_pkg::*;

   data_type value_ff;
   data_type value_in;

   always_comb begin
      value_in = value_ff;
      case (ctrl.op)
         OP_INSERT: begin
            if (cell_idx == ctrl.ins_idx) begin
               value_in = ctrl.value;
            end else if (cell_idx > ctrl.ins_idx) begin
               value_in = prev_value;
            end
         end
         OP_ROTATE: begin
            if (cell_idx == ctrl.tail_idx) begin
               value_in = head_value;
            end else if (cell_idx < ctrl.tail_idx) begin
               value_in = next_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

>>> hw/rtl/ordered_list_insert_at_position.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_at_position
// Ordered list of signed values with insert at a 1-based position and dump.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells. On an insert every cell behind
// the insert point moves back by one in parallel and one status item is
// returned. A dump returns one item per stored value, front to back, starting
// once the dump state has been entered and the first item registered, and
// then one per cycle while the response side keeps taking them; the row
// rotates forward one cell per item, so after the last item the list is back
// in place. A dump of an empty list returns
// nothing. No new request is taken while a dump is running.
module ordered_list_insert_at_position (
   input  logic       clock,
   input  logic       reset,
   olip_req_if.sink   req,
   olip_rsp_if.source rsp
);
   import olip_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

   state_type     state_ff, state_in;
   cnt_type       count_ff, count_in;
   cnt_type       remain_ff, remain_in;
   logic          rsp_valid_ff, rsp_valid_in;
   status_type    rsp_status_ff, rsp_status_in;
   data_type      rsp_element_ff, rsp_element_in;
   logic          rsp_last_ff, rsp_last_in;

   cell_ctrl_type ctrl;
   data_type      cell_value [CAPACITY];

   logic          rsp_free;
   logic          accept;
   logic          bad_pos;
   logic          full;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         localparam int PREV = (g == 0) ? 0 : g - 1;
         localparam int NEXT = (g + 1) % CAPACITY;
         olip_cell u_cell (
            .clock      (clock),
            .cell_idx   (IDX_W'(g)),
            .ctrl       (ctrl),
            .prev_value (cell_value[PREV]),
            .next_value (cell_value[NEXT]),
            .head_value (cell_value[0]),
            .value      (cell_value[g])
         );
      end
   endgenerate

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && rsp_free;
   assign accept    = req.valid && req.ready;
   assign bad_pos   = (req.position == '0) ||
                      (CMP_W'(req.position) > (CMP_W'(count_ff) + CMP_W'(1)));
   assign full      = (count_ff == CNT_W'(CAPACITY));

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      remain_in      = remain_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;
      ctrl.op        = OP_HOLD;
      ctrl.ins_idx   = IDX_W'(req.position - POS_W'(1));
      ctrl.tail_idx  = IDX_W'(count_ff - CNT_W'(1));
      ctrl.value     = req.value;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req.cmd == CMD_DUMP) begin
                  if (count_ff != '0) begin
                     state_in  = S_DUMP;
                     remain_in = count_ff;
                  end
               end else begin
                  rsp_valid_in   = 1'b1;
                  rsp_element_in = '0;
                  rsp_last_in    = 1'b1;
                  if (bad_pos) begin
                     rsp_status_in = ST_BADPOS;
                  end else if (full) begin
                     rsp_status_in = ST_FULL;
                  end else begin
                     rsp_status_in = ST_OK;
                     ctrl.op       = OP_INSERT;
                     count_in      = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         S_DUMP: begin
            if (rsp_free) begin
               ctrl.op        = OP_ROTATE;
               rsp_valid_in   = 1'b1;
               rsp_status_in  = ST_OK;
               rsp_element_in = cell_value[0];
               rsp_last_in    = (remain_ff == CNT_W'(1));
               remain_in      = remain_ff - CNT_W'(1);
               if (remain_ff == CNT_W'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff  <= rsp_status_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.status  = rsp_status_ff;
   assign rsp.element = rsp_element_ff;
   assign rsp.last    = rsp_last_ff;

endmodule

>>> tb/sv/tb_ordered_list_insert_at_position.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_at_position
// Self-checking bench for the ordered list insert block.
// ----------------------------------------------------------------------------
// A queue of insert and dump items is built up front: a directed opening
// (empty list, bad positions, front, middle and back inserts, extreme values),
// then random traffic that fills the list and keeps hitting it once full.
// A clocked driver offers the items with random gaps. A clocked monitor
// tracks the list contents on every accepted item, builds the replies it
// must produce, and compares each accepted reply field by field. The reply
// side stalls at random, once for a long stretch, and the sender waits for
// every due reply to come back at chosen points.
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_at_position;
   import olip_pkg::*;

   localparam int RANDOM_ITEMS   = 95;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 20;
   localparam int LONG_HOLD      = 100;

   typedef struct {
      logic     cmd;
      data_type value;
      pos_type  position;
      int       gap;
      bit       drain_first;
   } list_cmd_type;

   typedef struct {
      status_type status;
      data_type   element;
      logic       last;
   } list_reply_type;

   logic clock;
   logic reset;

   olip_req_if req_if();
   olip_rsp_if rsp_if();

   ordered_list_insert_at_position uut (
      .clock (clock),
      .reset (reset),
      .req   (req_if),
      .rsp   (rsp_if)
   );

   list_cmd_type   commands_pending[$];
   list_reply_type replies_due[$];
   data_type       list_model[$];

   int planned_len     = 0;
   int errors          = 0;
   int inserts_seen    = 0;
   int dumps_seen      = 0;
   int ok_seen         = 0;
   int badpos_seen     = 0;
   int full_seen       = 0;
   int longest_dump    = 0;
   int replies_checked = 0;
   int idle_cycles     = 0;
   int send_wait;
   int take_wait;
   int take_gap;
   int replies_taken;
   int long_hold;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic data_type pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return -32'sd1;
         default: return data_type'($urandom);
      endcase
   endfunction

   task automatic queue_command(logic cmd, data_type value, pos_type position, int gap,
                                bit drain_first);
      list_cmd_type c;
      c.cmd         = cmd;
      c.value       = value;
      c.position    = position;
      c.gap         = gap;
      c.drain_first = drain_first;
      commands_pending.push_back(c);
      if (cmd == CMD_INSERT && position >= 1 && int'(position) <= planned_len + 1 &&
          planned_len < CAPACITY)
         planned_len++;
   endtask

   function automatic void due_reply(status_type status, data_type element, logic last);
      list_reply_type r;
      r.status  = status;
      r.element = element;
      r.last    = last;
      replies_due.push_back(r);
   endfunction

   function automatic void apply_list_command(logic cmd, data_type value, pos_type position);
      int slot;
      slot = int'(position);
      if (cmd == CMD_DUMP) begin
         dumps_seen++;
         if (list_model.size() > longest_dump)
            longest_dump = list_model.size();
         for (int i = 0; i < list_model.size(); i++)
            due_reply(ST_OK, list_model[i], logic'(i == list_model.size() - 1));
      end else begin
         inserts_seen++;
         if (slot < 1 || slot > list_model.size() + 1) begin
            badpos_seen++;
            due_reply(ST_BADPOS, '0, 1'b1);
         end else if (list_model.size() >= CAPACITY) begin
            full_seen++;
            due_reply(ST_FULL, '0, 1'b1);
         end else begin
            ok_seen++;
            list_model.insert(slot - 1, value);
            due_reply(ST_OK, '0, 1'b1);
         end
      end
   endfunction

   always @(posedge clock) begin : driver
      list_cmd_type nxt;
      if (reset) begin
         req_if.valid    <= 1'b0;
         req_if.cmd      <= CMD_INSERT;
         req_if.value    <= '0;
         req_if.position <= '0;
         send_wait = 0;
      end else if (!req_if.valid || req_if.ready) begin
         if (commands_pending.size() > 0 && send_wait < commands_pending[0].gap) begin
            send_wait++;
            req_if.valid <= 1'b0;
         end else if (commands_pending.size() > 0 &&
                      (!commands_pending[0].drain_first ||
                       (!req_if.valid && replies_due.size() == 0))) begin
            nxt = commands_pending.pop_front();
            req_if.valid    <= 1'b1;
            req_if.cmd      <= nxt.cmd;
            req_if.value    <= nxt.value;
            req_if.position <= nxt.position;
            send_wait = 0;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : receiver
      logic take;
      if (reset) begin
         rsp_if.ready <= 1'b0;
         take_wait     = 0;
         take_gap      = 0;
         replies_taken = 0;
         long_hold     = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            replies_taken++;
            take_wait = 0;
            take_gap  = (replies_taken >= 60 && replies_taken < 120) ? 0 :
                        $urandom_range(0, 8);
            if (replies_taken == 40)
               long_hold = LONG_HOLD;
         end
         if (long_hold > 0) begin
            long_hold--;
            take = 1'b0;
         end else if (take_wait < take_gap) begin
            take_wait++;
            take = 1'b0;
         end else begin
            take = 1'b1;
         end
         rsp_if.ready <= take;
      end
   end

   always @(posedge clock) begin : monitor
      list_reply_type want;
      bit             moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_if.valid && req_if.ready) begin
            apply_list_command(req_if.cmd, req_if.value, req_if.position);
            moved = 1'b1;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            moved = 1'b1;
            replies_checked++;
            if (replies_due.size() == 0) begin
               $error("reply with nothing due: status %0d element %0d last %0b",
                      rsp_if.status, rsp_if.element, rsp_if.last);
               errors++;
            end else begin
               want = replies_due.pop_front();
               if (rsp_if.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_if.status);
                  errors++;
               end
               if (rsp_if.element !== want.element) begin
                  $error("element: expected %0d, got %0d", want.element, rsp_if.element);
                  errors++;
               end
               if (rsp_if.last !== want.last) begin
                  $error("last: expected %0b, got %0b", want.last, rsp_if.last);
                  errors++;
               end
            end
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles, %0d replies still due",
                     idle_cycles, replies_due.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      int  r;
      int  gap;
      logic     cmd;
      pos_type  position;

      reset = 1'b1;

      queue_command(CMD_DUMP,   '0,                    5'd0,  $urandom_range(0, 8), 1'b0);
      queue_command(CMD_INSERT, 32'sd7,                5'd2,  $urandom_range(0, 8), 1'b0);
      queue_command(CMD_INSERT, 32'sd9,                5'd0,  $urandom_range(0, 8), 1'b0);
      queue_command(CMD_INSERT, 32'sd11,               5'd31, $urandom_range(0, 8), 1'b0);
      queue_command(CMD_INSERT, 32'sh7FFF_FFFF,        5'd1,  $urandom_range(0, 8), 1'b0);
      queue_command(CMD_INSERT, 32'sh8000_0000,        5'd1,  $urandom_range(0, 8), 1'b0);
      queue_command(CMD_INSERT, -32'sd1,               5'd3,  $urandom_range(0, 8), 1'b0);
      queue_command(CMD_INSERT, 32'sd0,                5'd2,  $urandom_range(0, 8), 1'b0);
      queue_command(CMD_INSERT, 32'sd13,               5'd6,  $urandom_range(0, 8), 1'b0);
      queue_command(CMD_DUMP,   '0,                    5'd0,  $urandom_range(0, 8), 1'b0);
      queue_command(CMD_INSERT, 32'sh5555_5555,        5'd5,  0,                    1'b0);
      queue_command(CMD_DUMP,   32'shAAAA_AAAA,        5'd31, 0,                    1'b0);
      queue_command(CMD_INSERT, 32'shAAAA_AAAA,        5'd1,  $urandom_range(0, 8), 1'b1);
      queue_command(CMD_INSERT, 32'sd17,               5'd8,  $urandom_range(0, 8), 1'b0);
      queue_command(CMD_DUMP,   -32'sd1,               5'd15, $urandom_range(0, 8), 1'b0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r   = $urandom_range(0, 99);
         gap = (n >= 10 && n < 35) ? 0 : $urandom_range(0, 8);
         cmd = CMD_INSERT;
         if (r < 25) begin
            cmd      = CMD_DUMP;
            position = pos_type'($urandom);
         end else if (r < 33 && planned_len < CAPACITY) begin
            position = pos_type'($urandom_range(1, planned_len + 1));
         end else if (r < 37) begin
            position = ($urandom_range(0, 1) == 0) ? pos_type'(1) : pos_type'(planned_len + 1);
         end else if (r < 42) begin
            position = pos_type'(planned_len + 2);
         end else begin
            position = pos_type'($urandom);
         end
         queue_command(cmd, pick_value(), position, gap, n == 70 || n == 90);
      end

      @(posedge clock);
      @(posedge clock);
      reset <= 1'b0;

      do
         @(posedge clock);
      while (commands_pending.size() > 0 || req_if.valid || replies_due.size() > 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("run: %0d inserts (%0d ok, %0d bad position, %0d full), %0d dumps",
               inserts_seen, ok_seen, badpos_seen, full_seen, dumps_seen);
      $display("run: %0d replies checked, longest dump %0d values, %0d mismatches",
               replies_checked, longest_dump, errors);
      if (errors == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
